// File: rtl/core/ffha_pkg.sv
`default_nettype none

package ffha_pkg;

  // arena defaults and fixed header layout
  localparam int ARENA_BYTES_DEF = 8192;
  localparam int HEADER_BYTES    = 4;
  localparam int WORD_MASK       = 3;
  localparam int WORD_SHIFT      = 2;

  // fixed field widths
  localparam int SIZE_IN_W = 16;
  localparam int OFF_IN_W  = 13;
  localparam int NEED_W    = 17;
  localparam int STATUS_W  = 2;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // header memory operations
  localparam logic [3:0] MEM_NONE     = 4'd0;
  localparam logic [3:0] MEM_RD_CUR   = 4'd1;
  localparam logic [3:0] MEM_RD_NODE  = 4'd2;
  localparam logic [3:0] MEM_RD_SUCC  = 4'd3;
  localparam logic [3:0] MEM_WR_INIT  = 4'd4;
  localparam logic [3:0] MEM_WR_WHOLE = 4'd5;
  localparam logic [3:0] MEM_WR_REM   = 4'd6;
  localparam logic [3:0] MEM_WR_HEAD  = 4'd7;
  localparam logic [3:0] MEM_WR_WORK  = 4'd8;

  typedef struct packed {
    logic                load;
    logic [3:0]          mem_op;
    logic                adv;
    logic                grab_pred;
    logic                work_node;
    logic                work_succ;
    logic                res_load;
    logic [STATUS_W-1:0] res_code;
    logic                res_pay;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic too_big;
    logic bad_off;
    logic node_zero;
    logic fit;
    logic exact;
    logic no_split;
    logic next_zero;
    logic hit;
    logic succ_cand;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ffha_ram.sv
`default_nettype none

module ffha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/ffha_datapath.sv
`default_nettype none

module ffha_datapath
  import ffha_pkg::*;
#(
  parameter int ARENA_BYTES = ARENA_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic                 req_type,
  input  wire logic [SIZE_IN_W-1:0] size_bytes,
  input  wire logic [OFF_IN_W-1:0]  block_offset,
  output logic      [STATUS_W-1:0]  status,
  output logic      [OFF_IN_W-1:0]  payload_offset
);

  localparam int OFF_W = $clog2(ARENA_BYTES);
  localparam int SZ_W  = $clog2(ARENA_BYTES + 1);
  localparam int WORDS = ARENA_BYTES / (WORD_MASK + 1);
  localparam int AW    = $clog2(WORDS);
  localparam int HW    = OFF_W + SZ_W + 1;

  // captured request
  logic                req_free;
  logic                size_zero;
  logic [NEED_W-1:0]   need;
  logic [OFF_IN_W-1:0] boff;

  // walk pointer, predecessor and working header
  logic [OFF_W-1:0] cur;
  logic [SZ_W-1:0]  p_size;
  logic             p_used;
  logic [OFF_W-1:0] w_addr;
  logic [OFF_W-1:0] w_next;
  logic [SZ_W-1:0]  w_size;

  // result and output registers
  logic [STATUS_W-1:0] res_code;
  logic [OFF_IN_W-1:0] res_pay;

  // header memory
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [HW-1:0] ram_wdata;
  logic [HW-1:0] ram_rdata;

  logic [OFF_W-1:0] rd_next;
  logic [SZ_W-1:0]  rd_size;
  logic             rd_used;

  logic [NEED_W:0]     sum_in;
  logic [NEED_W-1:0]   need_in;
  logic [OFF_IN_W-1:0] node13;
  logic [OFF_W-1:0]    node_off;
  logic [SZ_W-1:0]     need_sz;
  logic [OFF_W-1:0]    split_off;
  logic [OFF_W-1:0]    pay_sum;
  logic                merge_pred;
  logic [SZ_W:0]       pred_end;
  logic [SZ_W:0]       work_end;

  assign rd_next = ram_rdata[HW-1 -: OFF_W];
  assign rd_size = ram_rdata[SZ_W:1];
  assign rd_used = ram_rdata[0];

  // round up to whole words and add the header
  assign sum_in  = {2'b00, size_bytes} + (NEED_W + 1)'(WORD_MASK);
  assign need_in = {sum_in[NEED_W-1:WORD_SHIFT], WORD_SHIFT'(0)} + NEED_W'(HEADER_BYTES);

  assign node13    = boff - OFF_IN_W'(HEADER_BYTES);
  assign node_off  = OFF_W'(node13);
  assign need_sz   = need[SZ_W-1:0];
  assign split_off = OFF_W'(SZ_W'(cur) + need_sz);
  assign pay_sum   = OFF_W'(cur + OFF_W'(HEADER_BYTES));
  assign pred_end  = {1'b0, SZ_W'(cur)} + {1'b0, p_size};
  assign work_end  = {1'b0, SZ_W'(w_addr)} + {1'b0, w_size};
  assign merge_pred = !sts.node_zero && !p_used && (pred_end == (SZ_W + 1)'(node_off));

  always_comb begin
    sts.is_free   = req_free;
    sts.zero_req  = size_zero;
    sts.too_big   = need > NEED_W'(ARENA_BYTES);
    sts.bad_off   = (boff < OFF_IN_W'(HEADER_BYTES)) || (boff[1:0] != 2'b00) ||
                    (32'(node13) >= 32'(ARENA_BYTES));
    sts.node_zero = node13 == '0;
    sts.fit       = !rd_used && (need <= NEED_W'(rd_size));
    sts.exact     = need == NEED_W'(rd_size);
    sts.no_split  = ({1'b0, need} + (NEED_W + 1)'(HEADER_BYTES)) > (NEED_W + 1)'(rd_size);
    sts.next_zero = rd_next == '0;
    sts.hit       = rd_next == node_off;
    sts.succ_cand = (w_next != '0) && (work_end == (SZ_W + 1)'(w_next));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cur[AW+1:2];
    ram_wdata = {w_next, w_size, 1'b0};
    case (cmd.mem_op)
      MEM_NONE: ;
      MEM_RD_CUR: ram_addr = cur[AW+1:2];
      MEM_RD_NODE: ram_addr = node_off[AW+1:2];
      MEM_RD_SUCC: ram_addr = w_next[AW+1:2];
      MEM_WR_INIT: begin
        ram_we    = 1'b1;
        ram_addr  = '0;
        ram_wdata = {OFF_W'(0), SZ_W'(ARENA_BYTES), 1'b0};
      end
      MEM_WR_WHOLE: begin
        ram_we    = 1'b1;
        ram_wdata = {rd_next, rd_size, 1'b1};
      end
      MEM_WR_REM: begin
        ram_we    = 1'b1;
        ram_addr  = split_off[AW+1:2];
        ram_wdata = {rd_next, rd_size - need_sz, 1'b0};
      end
      MEM_WR_HEAD: begin
        ram_we    = 1'b1;
        ram_wdata = {split_off, need_sz, 1'b1};
      end
      MEM_WR_WORK: begin
        ram_we    = 1'b1;
        ram_addr  = w_addr[AW+1:2];
        ram_wdata = {w_next, w_size, 1'b0};
      end
      default: ;
    endcase
  end

  ffha_ram #(
    .WIDTH(HW),
    .DEPTH(WORDS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_free  <= req_type == REQ_FREE;
      size_zero <= size_bytes == '0;
      need      <= need_in;
      boff      <= block_offset;
      cur       <= '0;
    end else if (cmd.adv) begin
      cur <= rd_next;
    end
    if (cmd.grab_pred) begin
      p_size <= rd_size;
      p_used <= rd_used;
    end
    // freed block, folded into a free predecessor when they touch
    if (cmd.work_node) begin
      w_next <= rd_next;
      if (merge_pred) begin
        w_addr <= cur;
        w_size <= p_size + rd_size;
      end else begin
        w_addr <= node_off;
        w_size <= rd_size;
      end
    end else if (cmd.work_succ && !rd_used) begin
      w_next <= rd_next;
      w_size <= w_size + rd_size;
    end
    if (cmd.res_load) begin
      res_code <= cmd.res_code;
      res_pay  <= cmd.res_pay ? OFF_IN_W'(pay_sum) : '0;
    end
    if (cmd.out_load) begin
      status         <= res_code;
      payload_offset <= res_pay;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ffha_ctrl.sv
`default_nettype none

module ffha_ctrl
  import ffha_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_A_RD   = 4'd3;
  localparam logic [3:0] S_A_EV   = 4'd4;
  localparam logic [3:0] S_A_SPL  = 4'd5;
  localparam logic [3:0] S_F_RD   = 4'd6;
  localparam logic [3:0] S_F_EV   = 4'd7;
  localparam logic [3:0] S_F_NRD  = 4'd8;
  localparam logic [3:0] S_F_NEV  = 4'd9;
  localparam logic [3:0] S_F_SCHK = 4'd10;
  localparam logic [3:0] S_F_SEV  = 4'd11;
  localparam logic [3:0] S_F_WR   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       slot_free;

  assign in_ready  = state == S_IDLE;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.mem_op = MEM_WR_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!sts.is_free) begin
          if (sts.zero_req) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_ZERO;
            state_next   = S_DONE;
          end else if (sts.too_big) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_NOFIT;
            state_next   = S_DONE;
          end else begin
            state_next = S_A_RD;
          end
        end else if (sts.bad_off) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_NOTFOUND;
          state_next   = S_DONE;
        end else if (sts.node_zero) begin
          state_next = S_F_NRD;
        end else begin
          state_next = S_F_RD;
        end
      end
      S_A_RD: begin
        cmd.mem_op = MEM_RD_CUR;
        state_next = S_A_EV;
      end
      S_A_EV: begin
        if (sts.fit && sts.exact) begin
          cmd.mem_op   = MEM_WR_WHOLE;
          cmd.res_load = 1'b1;
          cmd.res_code = ST_OK;
          cmd.res_pay  = 1'b1;
          state_next   = S_DONE;
        end else if (sts.fit && !sts.no_split) begin
          cmd.mem_op = MEM_WR_REM;
          state_next = S_A_SPL;
        end else if (sts.next_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_NOFIT;
          state_next   = S_DONE;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_A_RD;
        end
      end
      S_A_SPL: begin
        cmd.mem_op   = MEM_WR_HEAD;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_OK;
        cmd.res_pay  = 1'b1;
        state_next   = S_DONE;
      end
      S_F_RD: begin
        cmd.mem_op = MEM_RD_CUR;
        state_next = S_F_EV;
      end
      S_F_EV: begin
        cmd.grab_pred = 1'b1;
        if (sts.next_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_NOTFOUND;
          state_next   = S_DONE;
        end else if (sts.hit) begin
          state_next = S_F_NRD;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_F_RD;
        end
      end
      S_F_NRD: begin
        cmd.mem_op = MEM_RD_NODE;
        state_next = S_F_NEV;
      end
      S_F_NEV: begin
        cmd.work_node = 1'b1;
        state_next    = S_F_SCHK;
      end
      S_F_SCHK: begin
        if (sts.succ_cand) begin
          cmd.mem_op = MEM_RD_SUCC;
          state_next = S_F_SEV;
        end else begin
          cmd.mem_op   = MEM_WR_WORK;
          cmd.res_load = 1'b1;
          cmd.res_code = ST_OK;
          state_next   = S_DONE;
        end
      end
      S_F_SEV: begin
        cmd.work_succ = 1'b1;
        state_next    = S_F_WR;
      end
      S_F_WR: begin
        cmd.mem_op   = MEM_WR_WORK;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_OK;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/first_fit_heap_allocator_unit.sv
// first-fit heap allocator over a byte arena kept as an address-ordered block chain
// input channel: in_valid/in_ready with req_type (0 allocate, 1 free), size_bytes
//   and block_offset; output channel: out_valid/out_ready with status and
//   payload_offset, one result beat per request beat
// one request is in flight at a time; every chain step is one read of the single
//   header memory port followed by an evaluate step
// an allocate walks the chain, reading and evaluating one header per step, up to
//   the first fit or the chain end, then writes the header; a split writes the
//   remainder first and then the allocated header
// a free walks to the predecessor the same way, reads the freed node and writes
//   the merged header, reading the successor first when it may merge; an offset
//   missing from the chain answers once the walk reaches the chain end
// zero-size, oversized or malformed-offset requests answer straight from the check
// in_ready rises together with out_valid
// reset: the init state writes the single free block covering the arena at word 0,
//   in_ready rises on the cycle after that
// the result sits in an output register; when the receiver stalls the block
//   still accepts the next request and holds its finished result until the
//   register drains
`default_nettype none

module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int ARENA_BYTES = ARENA_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 req_type,
  input  wire logic [SIZE_IN_W-1:0] size_bytes,
  input  wire logic [OFF_IN_W-1:0]  block_offset,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [STATUS_W-1:0]  status,
  output logic      [OFF_IN_W-1:0]  payload_offset
);

  cmd_t cmd;
  sts_t sts;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffha_datapath #(
    .ARENA_BYTES(ARENA_BYTES)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .size_bytes    (size_bytes),
    .block_offset  (block_offset),
    .status        (status),
    .payload_offset(payload_offset)
  );

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_fail_zero_pay: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> payload_offset == '0)
    else $error("failed request carries a payload offset");

  a_pay_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> payload_offset[1:0] == 2'b00)
    else $error("payload offset not word aligned");

  // header init cycle blocks requests right after reset
  a_reset_init: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

`default_nettype wire
